// ===== rtl/plt_pkg.sv =====
// Shared types and constants for the packed line table lookup unit.
`timescale 1ns / 1ps

package plt_pkg;

  localparam int WORD_BITS        = 32;
  localparam int MAX_VARINT_BYTES = (WORD_BITS + 6) / 7;
  localparam int IDX_W            = $clog2(MAX_VARINT_BYTES);
  localparam int EXT_W            = WORD_BITS + 32;
  localparam int GROUP_BITS       = 7;

  localparam logic [7:0] GROUP_MASK = 8'h7f;
  localparam logic [7:0] MORE_FLAG  = 8'h80;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_VARINT_BYTES - 1);

  typedef struct packed {
    logic [7:0]  map_byte;
    logic        byte_present;
    logic [31:0] query_pc;
    logic        first_item;
    logic        last_item;
  } plt_item_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] pc_hold;
    logic [WORD_BITS-1:0] position_sum;
    logic [WORD_BITS-1:0] line_sum;
    logic [WORD_BITS-1:0] varint_value;
    logic [IDX_W-1:0]     byte_index;
    logic                 second_of_pair;
    logic                 line_frozen;
  } plt_state_t;

  typedef struct packed {
    logic [31:0] line_number;
    logic        pair_cut_short;
  } plt_result_t;

endpackage

// ===== rtl/plt_step.sv =====
// Per-byte varint decode and position/line accumulation, purely combinational.
`timescale 1ns / 1ps

module plt_step
  import plt_pkg::*;
(
  input  plt_item_t   item,
  input  plt_state_t  state,
  output plt_state_t  state_nxt,
  output plt_result_t result
);

  plt_state_t           base;
  logic [EXT_W-1:0]     pc_ext;
  logic [EXT_W-1:0]     group_ext;
  logic [WORD_BITS-1:0] value_or;
  logic [WORD_BITS-1:0] pos_add;
  logic [WORD_BITS-1:0] line_add;
  logic                 done;
  logic [31:0]          line_trim;
  logic [EXT_W-1:0]     line_ext;

  always_comb begin
    pc_ext    = {{(EXT_W-32){1'b0}}, item.query_pc};
    base      = state;
    if (item.first_item) begin
      base         = '0;
      base.pc_hold = pc_ext[WORD_BITS-1:0];
    end

    // 7*idx stays below WORD_BITS for every legal index
    group_ext = {{(EXT_W-8){1'b0}}, item.map_byte & GROUP_MASK}
                << (GROUP_BITS * int'(base.byte_index));
    value_or  = base.varint_value | group_ext[WORD_BITS-1:0];
    done      = ((item.map_byte & MORE_FLAG) == 8'h00) || (base.byte_index == LAST_IDX);
    pos_add   = base.position_sum + value_or;
    line_add  = base.line_sum + value_or;

    state_nxt = base;
    if (item.byte_present && !base.line_frozen) begin
      if (!done) begin
        state_nxt.varint_value = value_or;
        state_nxt.byte_index   = base.byte_index + IDX_W'(1);
      end else begin
        state_nxt.varint_value = '0;
        state_nxt.byte_index   = '0;
        if (!base.second_of_pair) begin
          state_nxt.position_sum   = pos_add;
          state_nxt.second_of_pair = 1'b1;
          if (base.pc_hold < pos_add) begin
            state_nxt.line_frozen = 1'b1;
          end
        end else begin
          state_nxt.line_sum       = line_add;
          state_nxt.second_of_pair = 1'b0;
        end
      end
    end

    line_ext  = {{(EXT_W-WORD_BITS){1'b0}}, state_nxt.line_sum};
    line_trim = line_ext[31:0];
    result.line_number    = line_trim;
    result.pair_cut_short = !state_nxt.line_frozen &&
                            (state_nxt.second_of_pair || (state_nxt.byte_index != '0));
  end

endmodule

// ===== rtl/packed_line_table_lookup_unit.sv =====
// Top level of the packed line table lookup unit: input stage, query state and result register.
`timescale 1ns / 1ps

// Packed line table lookup. Feed the bytes of a packed line map one beat at a time;
// the first beat of a query carries first_item and the query pc, the final beat
// carries tlast. Each byte adds seven bits to an unsigned LEB128 varint (ending on
// a clear bit 7 or after the fifth byte); varints pair up as position delta and
// line delta, and once the running position passes the query pc the line is
// frozen. The tlast beat yields one result beat with the line number and a flag
// that is set when an unfrozen query stopped inside an unfinished pair. A beat
// without a byte (byte_present low) only moves the query along; first and last on
// such a beat is an empty query and gives line 0. Throughput is one byte per
// cycle while no tlast beat waits on a held result: the beat sits in the input
// register while the state loop (one shift-and-OR, one 32-bit add and one
// compare) updates the query state. The result is registered into the output
// register as the tlast beat leaves the input register, and result valid rises
// with it. The output register frees the input side, so new bytes keep flowing
// while a result waits to be taken; only the next tlast beat waits in the input
// register until the held result has gone.

module packed_line_table_lookup_unit
  import plt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] map_byte, [39:8] query_pc
  input  logic [1:0]  in_tuser,   // [0] byte_present, [1] first_item
  input  logic        in_tlast,   // last_item
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] line_number
  output logic [0:0]  out_tuser   // [0] pair_cut_short
);

  // input stage
  logic        s1_valid_r;
  plt_item_t   s1_item_r;
  // query state
  plt_state_t  state_r;
  plt_state_t  state_nxt;
  plt_result_t result;
  // result register
  logic        out_valid_r;
  plt_result_t out_r;

  logic s1_adv;
  logic in_acc;

  // A beat with no result never waits on the output side
  assign s1_adv    = s1_valid_r && (!s1_item_r.last_item || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  plt_step u_step (
    .item      (s1_item_r),
    .state     (state_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.map_byte     <= in_tdata[7:0];
      s1_item_r.query_pc     <= in_tdata[39:8];
      s1_item_r.byte_present <= in_tuser[0];
      s1_item_r.first_item   <= in_tuser[1];
      s1_item_r.last_item    <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_item_r.last_item) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_item_r.last_item) begin
      out_r <= result;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_r.line_number;
  assign out_tuser[0] = out_r.pair_cut_short;

  // a held result is never overwritten by a new one
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !(s1_adv && s1_item_r.last_item))
    else $error("result register overwritten while stalled");

  // varint byte index never passes the last byte index
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.byte_index <= LAST_IDX)
    else $error("varint byte index out of range");

  // a frozen line stays put until a new query starts
  a_frozen_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.line_frozen && !(s1_adv && s1_item_r.first_item)
    |=> $stable(state_r.line_sum) && state_r.line_frozen)
    else $error("frozen line changed");

  // a stalled input stage blocks new beats
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |-> !in_tready)
    else $error("input accepted while stage stalled");

endmodule
